// ===== sv/tlqe_pkg.sv =====
// Package for the thick line quad expander: fixed widths, request and
// result structs, the segment kind code and the color clamp.
// No dependencies.
`default_nettype none

package tlqe_pkg;

	localparam int COORD_W = 24;
	localparam int COLOR_W = 16;
	localparam int CLR_W   = 13;
	localparam int CFG_W   = 48;

	// Derived datapath widths.
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MAG_W   = COORD_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int LSQ_W   = SQ_W + 1;
	localparam int PROD_W  = MAG_W + COORD_W - 1;
	localparam int RAD_W   = 64;
	localparam int RAD_SHIFT = 14;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int FRAC_SHIFT = 7;
	localparam int DVD_W   = PROD_W + FRAC_SHIFT + 1;
	localparam int DIV_W   = ROOT_W + 1;
	localparam int DREM_W  = DIV_W + 1;
	localparam int Q_W     = COORD_W;
	localparam int DIV_STAGES = Q_W;
	localparam int OFF_W   = Q_W + 1;
	localparam int SUM_W   = COORD_W + 2;

	localparam logic [CLR_W-1:0] COLOR_ONE = CLR_W'(4096);

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] thickness;
		logic signed [COLOR_W-1:0] in_red;
		logic signed [COLOR_W-1:0] in_green;
		logic signed [COLOR_W-1:0] in_blue;
	} seg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic [CLR_W-1:0]          vert_red;
		logic [CLR_W-1:0]          vert_green;
		logic [CLR_W-1:0]          vert_blue;
		logic                      to_line_list;
		logic                      rejected;
		logic                      last;
	} res_t;

	typedef enum logic [1:0] {
		KIND_THIN,
		KIND_REJECT,
		KIND_THICK
	} kind_t;

	function automatic logic [CLR_W-1:0] clamp_color(input logic signed [COLOR_W-1:0] c);
		logic [CLR_W-1:0] r;
		if (c[COLOR_W-1]) begin
			r = '0;
		end else if ($unsigned(c) > COLOR_W'(COLOR_ONE)) begin
			r = COLOR_ONE;
		end else begin
			r = CLR_W'($unsigned(c));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/tlqe_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on tlqe_pkg for widths.
`default_nettype none

module tlqe_sqrt_pipe (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tlqe_pkg::RAD_W-1:0]  radicand,
	output logic [tlqe_pkg::ROOT_W-1:0] root
);
	import tlqe_pkg::*;

	logic [RAD_W-1:0]  rad_s  [SQRT_STAGES];
	logic [REM_W-1:0]  rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_step
		logic [RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;

		if (i == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		// Bring down the next two radicand bits and try 4*root+1.
		assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i] <= rad_in << 2;
				if (rem_sh >= trial) begin
					rem_s[i]  <= rem_sh - trial;
					root_s[i] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= rem_sh;
					root_s[i] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/tlqe_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in Q_W bits. Depends on tlqe_pkg for widths.
`default_nettype none

module tlqe_div_pipe (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tlqe_pkg::DVD_W-1:0] dividend,
	input  logic [tlqe_pkg::DIV_W-1:0] divisor,
	output logic [tlqe_pkg::Q_W-1:0]   quo
);
	import tlqe_pkg::*;

	logic [DREM_W-1:0] rem_s [DIV_STAGES];
	logic [Q_W-1:0]    lo_s  [DIV_STAGES];
	logic [DIV_W-1:0]  div_s [DIV_STAGES];
	logic [Q_W-1:0]    q_s   [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
		logic [DREM_W-1:0] rem_in;
		logic [Q_W-1:0]    lo_in;
		logic [DIV_W-1:0]  div_in;
		logic [Q_W-1:0]    q_in;
		logic [DREM_W-1:0] rem_sh;

		if (i == 0) begin : g_first
			// The upper dividend bits are below the divisor since the quotient fits.
			assign rem_in = DREM_W'(dividend[DVD_W-1:Q_W]);
			assign lo_in  = dividend[Q_W-1:0];
			assign div_in = divisor;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign lo_in  = lo_s[i-1];
			assign div_in = div_s[i-1];
			assign q_in   = q_s[i-1];
		end

		assign rem_sh = {rem_in[DREM_W-2:0], lo_in[Q_W-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[i]  <= lo_in << 1;
				div_s[i] <= div_in;
				if (rem_sh >= {1'b0, div_in}) begin
					rem_s[i] <= rem_sh - {1'b0, div_in};
					q_s[i]   <= {q_in[Q_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= rem_sh;
					q_s[i]   <= {q_in[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = q_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/thick_line_quad_expander_top.sv =====
// Top level of the thick line quad expander: front stages, square root and
// divider pipelines, offset and saturation stage, and the vertex serializer.
// Depends on tlqe_pkg, tlqe_sqrt_pipe and tlqe_div_pipe.
//
//   channel   ports                   handshake
//   request   seg                     start, busy (taken when start && !busy)
//   result    res                     res_strobe, one cycle, cannot be held off
//   config    cfg_wdata               cfg_we, written at once
//
// A thick segment produces six results, one per cycle; a thin segment produces
// two results and a rejected one a single result. The serializer at the end of
// the pipeline sets the rate at which segments are taken. The first result of a
// request reaches the result ports through four front stages, 32 square root
// stages, the divisor stage, 24 divider stages, the offset stage, the serializer
// and the result register. Reset clears all valid bits and the threshold
// register. While the serializer is active and not on its last result and the
// last pipeline stage holds a segment, the whole pipeline holds and busy is high.
`default_nettype none

module thick_line_quad_expander_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  tlqe_pkg::seg_t             seg,
	input  logic                       cfg_we,
	input  logic [tlqe_pkg::CFG_W-1:0] cfg_wdata,
	output logic                       res_strobe,
	output tlqe_pkg::res_t             res
);
	import tlqe_pkg::*;

	localparam logic [2:0] LAST_THICK = 3'd5;

	typedef struct packed {
		logic [CLR_W-1:0] r;
		logic [CLR_W-1:0] g;
		logic [CLR_W-1:0] b;
	} color_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} pt_t;

	typedef struct packed {
		kind_t                     kind;
		logic                      neg_offx;
		logic                      neg_offy;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		color_t                    col;
	} geo_t;

	typedef struct packed {
		geo_t              geo;
		logic [PROD_W-1:0] prod_offx;
		logic [PROD_W-1:0] prod_offy;
	} side_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		logic signed [COORD_W-1:0] r;
		hi = $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}}));
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			r = hi[COORD_W-1:0];
		end else if (v < lo) begin
			r = lo[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	logic [CFG_W-1:0] min_len_q;
	logic en;
	logic take;
	logic ser_final;

	// Stage 1: differences, thin test, color clamp.
	logic v_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic thin_s1;
	logic signed [COORD_W-1:0] t_s1;
	geo_t geo_s1;
	geo_t geo_nx2;

	// Stage 2: magnitudes.
	logic v_s2;
	logic [MAG_W-1:0] ux_s2, uy_s2;
	logic thin_s2;
	logic signed [COORD_W-1:0] t_s2;
	geo_t geo_s2;

	// Stage 3: squares and thickness products.
	logic v_s3;
	logic [SQ_W-1:0] qx_s3, qy_s3;
	logic thin_s3;
	side_t side_s3;

	// Stage 4: squared length, reject test, radicand.
	logic v_s4;
	logic [RAD_W-1:0] rad_s4;
	side_t side_s4;
	side_t side_nx4;
	logic [LSQ_W-1:0] lsq;

	logic v_sq [SQRT_STAGES];
	side_t side_sq [SQRT_STAGES];
	logic [ROOT_W-1:0] root;

	// Stage 5: dividends and divisor.
	logic v_s5;
	logic [DVD_W-1:0] dvdx_s5, dvdy_s5;
	logic [DIV_W-1:0] divisor_s5;
	geo_t geo_s5;

	logic v_dv [DIV_STAGES];
	geo_t geo_dv [DIV_STAGES];
	logic [Q_W-1:0] qx, qy;

	// Stage 6: offsets applied, corners saturated.
	logic v_s6;
	kind_t kind_s6;
	color_t col_s6;
	pt_t pts_s6 [4];
	logic signed [OFF_W-1:0] offx, offy;
	geo_t g6;

	// Serializer.
	logic ser_act_q;
	logic [2:0] ser_cnt_q;
	kind_t ser_kind_q;
	color_t ser_col_q;
	pt_t ser_pt_q [4];
	logic [1:0] idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= '0;
		end else if (cfg_we) begin
			min_len_q <= cfg_wdata;
		end
	end

	assign take = v_s6 && (!ser_act_q || ser_final);
	assign en   = !v_s6 || take;
	assign busy = !en;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < SQRT_STAGES; i++) v_sq[i] <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++) v_dv[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sq[0] <= v_s4;
			for (int i = 1; i < SQRT_STAGES; i++) v_sq[i] <= v_sq[i-1];
			v_s5 <= v_sq[SQRT_STAGES-1];
			v_dv[0] <= v_s5;
			for (int i = 1; i < DIV_STAGES; i++) v_dv[i] <= v_dv[i-1];
			v_s6 <= v_dv[DIV_STAGES-1];
		end
	end

	assign lsq = LSQ_W'(qx_s3) + LSQ_W'(qy_s3);

	always_comb begin
		geo_nx2          = geo_s1;
		geo_nx2.neg_offx = !dy_s1[DIFF_W-1] && (dy_s1 != '0);
		geo_nx2.neg_offy = dx_s1[DIFF_W-1];
	end

	always_comb begin
		side_nx4 = side_s3;
		if (thin_s3) begin
			side_nx4.geo.kind = KIND_THIN;
		end else if (lsq <= LSQ_W'(min_len_q)) begin
			side_nx4.geo.kind = KIND_REJECT;
		end else begin
			side_nx4.geo.kind = KIND_THICK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1       <= DIFF_W'(seg.end_x) - DIFF_W'(seg.start_x);
			dy_s1       <= DIFF_W'(seg.end_y) - DIFF_W'(seg.start_y);
			thin_s1     <= seg.thickness[COORD_W-1] || (seg.thickness == '0);
			t_s1        <= seg.thickness;
			geo_s1.kind <= KIND_THICK;
			geo_s1.neg_offx <= 1'b0;
			geo_s1.neg_offy <= 1'b0;
			geo_s1.sx   <= seg.start_x;
			geo_s1.sy   <= seg.start_y;
			geo_s1.ex   <= seg.end_x;
			geo_s1.ey   <= seg.end_y;
			geo_s1.col  <= '{r: clamp_color(seg.in_red), g: clamp_color(seg.in_green),
				b: clamp_color(seg.in_blue)};

			ux_s2   <= dx_s1[DIFF_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
			uy_s2   <= dy_s1[DIFF_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
			thin_s2 <= thin_s1;
			t_s2    <= t_s1;
			geo_s2  <= geo_nx2;

			// The x offset scales with |dy| and the y offset with |dx|.
			qx_s3 <= ux_s2 * ux_s2;
			qy_s3 <= uy_s2 * uy_s2;
			side_s3.prod_offx <= uy_s2 * t_s2[COORD_W-2:0];
			side_s3.prod_offy <= ux_s2 * t_s2[COORD_W-2:0];
			side_s3.geo <= geo_s2;
			thin_s3 <= thin_s2;

			rad_s4  <= RAD_W'(lsq) << RAD_SHIFT;
			side_s4 <= side_nx4;

			side_sq[0] <= side_s4;
			for (int i = 1; i < SQRT_STAGES; i++) side_sq[i] <= side_sq[i-1];

			// Rounded quotient: (2*num + len) / (2*len) with num = prod * 64.
			dvdx_s5 <= (DVD_W'(side_sq[SQRT_STAGES-1].prod_offx) << FRAC_SHIFT) + DVD_W'(root);
			dvdy_s5 <= (DVD_W'(side_sq[SQRT_STAGES-1].prod_offy) << FRAC_SHIFT) + DVD_W'(root);
			divisor_s5 <= {root, 1'b0};
			geo_s5 <= side_sq[SQRT_STAGES-1].geo;

			geo_dv[0] <= geo_s5;
			for (int i = 1; i < DIV_STAGES; i++) geo_dv[i] <= geo_dv[i-1];
		end
	end

	tlqe_sqrt_pipe u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s4),
		.root     (root)
	);

	tlqe_div_pipe u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (dvdx_s5),
		.divisor  (divisor_s5),
		.quo      (qx)
	);

	tlqe_div_pipe u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (dvdy_s5),
		.divisor  (divisor_s5),
		.quo      (qy)
	);

	assign g6 = geo_dv[DIV_STAGES-1];

	always_comb begin
		offx = $signed({1'b0, qx});
		offy = $signed({1'b0, qy});
		if (g6.neg_offx) offx = -offx;
		if (g6.neg_offy) offy = -offy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s6 <= g6.kind;
			unique case (g6.kind)
				KIND_THIN: begin
					col_s6    <= g6.col;
					pts_s6[0] <= '{x: g6.sx, y: g6.sy};
					pts_s6[1] <= '{x: g6.ex, y: g6.ey};
					pts_s6[2] <= '0;
					pts_s6[3] <= '0;
				end
				KIND_THICK: begin
					col_s6    <= g6.col;
					pts_s6[0] <= '{x: sat_coord(SUM_W'(g6.sx) + SUM_W'(offx)),
						y: sat_coord(SUM_W'(g6.sy) + SUM_W'(offy))};
					pts_s6[1] <= '{x: sat_coord(SUM_W'(g6.ex) + SUM_W'(offx)),
						y: sat_coord(SUM_W'(g6.ey) + SUM_W'(offy))};
					pts_s6[2] <= '{x: sat_coord(SUM_W'(g6.ex) - SUM_W'(offx)),
						y: sat_coord(SUM_W'(g6.ey) - SUM_W'(offy))};
					pts_s6[3] <= '{x: sat_coord(SUM_W'(g6.sx) - SUM_W'(offx)),
						y: sat_coord(SUM_W'(g6.sy) - SUM_W'(offy))};
				end
				default: begin
					pts_s6[0] <= '0;
					pts_s6[1] <= '0;
					pts_s6[2] <= '0;
					pts_s6[3] <= '0;
					col_s6    <= '0;
				end
			endcase
		end
	end

	// The two triangles walk the corners as p0 p1 p2 p0 p2 p3.
	always_comb begin
		ser_final = 1'b0;
		idx = ser_cnt_q[1:0];
		unique case (ser_kind_q)
			KIND_THIN: ser_final = ser_act_q && (ser_cnt_q == 3'd1);
			KIND_THICK: begin
				ser_final = ser_act_q && (ser_cnt_q == LAST_THICK);
				unique case (ser_cnt_q)
					3'd0: idx = 2'd0;
					3'd1: idx = 2'd1;
					3'd2: idx = 2'd2;
					3'd3: idx = 2'd0;
					3'd4: idx = 2'd2;
					default: idx = 2'd3;
				endcase
			end
			default: ser_final = ser_act_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_act_q  <= 1'b0;
			ser_cnt_q  <= '0;
			res_strobe <= 1'b0;
		end else begin
			res_strobe <= ser_act_q;
			if (take) begin
				ser_act_q <= 1'b1;
				ser_cnt_q <= '0;
			end else if (ser_final) begin
				ser_act_q <= 1'b0;
			end else if (ser_act_q) begin
				ser_cnt_q <= ser_cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ser_kind_q <= kind_s6;
			ser_col_q  <= col_s6;
			for (int i = 0; i < 4; i++) ser_pt_q[i] <= pts_s6[i];
		end
		res.vertex_x     <= ser_pt_q[idx].x;
		res.vertex_y     <= ser_pt_q[idx].y;
		res.vert_red     <= ser_col_q.r;
		res.vert_green   <= ser_col_q.g;
		res.vert_blue    <= ser_col_q.b;
		res.to_line_list <= (ser_kind_q == KIND_THIN);
		res.rejected     <= (ser_kind_q == KIND_REJECT);
		res.last         <= ser_final;
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> v_s1)
		else $error("accepted request did not enter the first stage");

	a_ser_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ser_act_q |=> res_strobe)
		else $error("active serializer produced no result");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (v_s6 && ser_act_q && !ser_final))
		else $error("busy without a full output stage");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && res.rejected) |-> (res.last && res.vertex_x == '0 && !res.to_line_list))
		else $error("rejected result malformed");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for thick_line_quad_expander_top: drives segment requests, predicts
// the emitted vertices in the testbench and compares every result in order.
// Depends on tlqe_pkg and the top level of the block.
`timescale 1ns / 100ps
`default_nettype none

module tb;
	import tlqe_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	seg_t seg = '0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic res_strobe;
	res_t res;

	logic [CFG_W-1:0] threshold_sq = '0;
	res_t vertex_queue[$];
	int errors = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;

	always #4 clk = ~clk;

	thick_line_quad_expander_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .seg(seg),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .res_strobe(res_strobe), .res(res)
	);

	function automatic logic [CLR_W-1:0] sat_color(logic signed [COLOR_W-1:0] c);
		if (c < 0) return '0;
		if (c > 4096) return CLR_W'(4096);
		return CLR_W'(c);
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_xy(longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (COORD_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return COORD_W'(hi);
		if (v < lo) return COORD_W'(lo);
		return COORD_W'(v);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned half_width_offset(longint unsigned a,
			longint unsigned t, longint unsigned len);
		longint unsigned num;
		num = (a * t) << 6;
		return (2 * num + len) / (2 * len);
	endfunction

	function automatic res_t make_vertex(longint x, longint y, logic [CLR_W-1:0] r,
			logic [CLR_W-1:0] g, logic [CLR_W-1:0] b, logic line, logic fin);
		res_t v;
		v.vertex_x = sat_xy(x);
		v.vertex_y = sat_xy(y);
		v.vert_red = r;
		v.vert_green = g;
		v.vert_blue = b;
		v.to_line_list = line;
		v.rejected = 1'b0;
		v.last = fin;
		return v;
	endfunction

	function automatic void queue_vertex(res_t v);
		vertex_queue.insert(vertex_queue.size(), v);
	endfunction

	task automatic expand_segment(seg_t s);
		longint sx, sy, ex, ey, t, dx, dy, offx, offy;
		longint unsigned ux, uy, lsq, m, nx, ny, len;
		logic [CLR_W-1:0] r, g, b;
		res_t v;
		int k;
		sx = longint'(s.start_x); sy = longint'(s.start_y);
		ex = longint'(s.end_x); ey = longint'(s.end_y);
		t = longint'(s.thickness);
		r = sat_color(s.in_red); g = sat_color(s.in_green); b = sat_color(s.in_blue);
		if (t <= 0) begin
			queue_vertex(make_vertex(sx, sy, r, g, b, 1'b1, 1'b0));
			queue_vertex(make_vertex(ex, ey, r, g, b, 1'b1, 1'b1));
			return;
		end
		dx = ex - sx;
		dy = ey - sy;
		ux = dx < 0 ? -dx : dx;
		uy = dy < 0 ? -dy : dy;
		lsq = ux * ux + uy * uy;
		if (lsq <= threshold_sq) begin
			v = '0;
			v.rejected = 1'b1;
			v.last = 1'b1;
			queue_vertex(v);
			return;
		end
		m = ux > uy ? ux : uy;
		k = 0;
		while ((m >> k) >= (64'd1 << 24)) k++;
		nx = ux >> k;
		ny = uy >> k;
		len = root_floor((nx * nx + ny * ny) << 14);
		if (len == 0) len = 1;
		offx = half_width_offset(ny, t, len);
		offy = half_width_offset(nx, t, len);
		if (dy > 0) offx = -offx;
		if (dx < 0) offy = -offy;
		queue_vertex(make_vertex(sx + offx, sy + offy, r, g, b, 1'b0, 1'b0));
		queue_vertex(make_vertex(ex + offx, ey + offy, r, g, b, 1'b0, 1'b0));
		queue_vertex(make_vertex(ex - offx, ey - offy, r, g, b, 1'b0, 1'b0));
		queue_vertex(make_vertex(sx + offx, sy + offy, r, g, b, 1'b0, 1'b0));
		queue_vertex(make_vertex(ex - offx, ey - offy, r, g, b, 1'b0, 1'b0));
		queue_vertex(make_vertex(sx - offx, sy - offy, r, g, b, 1'b0, 1'b1));
	endtask

	// Results are compared at the rising edge that accepts them.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_strobe) begin
			if (vertex_queue.size() == 0) begin
				$display("%0t: unexpected result %p", $time, res);
				errors++;
			end else begin
				want = vertex_queue.pop_front();
				if (res.vertex_x !== want.vertex_x || res.vertex_y !== want.vertex_y ||
						res.vert_red !== want.vert_red || res.vert_green !== want.vert_green ||
						res.vert_blue !== want.vert_blue ||
						res.to_line_list !== want.to_line_list ||
						res.rejected !== want.rejected || res.last !== want.last) begin
					$display("%0t: expected %p actual %p", $time, want, res);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || res_strobe || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Start stays high into the next request unless a gap is taken here.
	task automatic random_gap();
		int n;
		if (gaps_on && $urandom_range(3) == 0) begin
			n = $urandom_range(5, 1);
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_segment(seg_t s);
		seg <= s;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expand_segment(s);
		@(negedge clk);
		random_gap();
	endtask

	// Idle wait before a threshold change: queue empty plus pipeline latency.
	task automatic drain();
		start <= 1'b0;
		while (vertex_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_threshold(logic [CFG_W-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		threshold_sq = v;
	endtask

	function automatic seg_t mk(int sx, int sy, int ex, int ey, int t,
			int r, int g, int b);
		seg_t s;
		s.start_x = COORD_W'(sx); s.start_y = COORD_W'(sy);
		s.end_x = COORD_W'(ex); s.end_y = COORD_W'(ey);
		s.thickness = COORD_W'(t);
		s.in_red = COLOR_W'(r); s.in_green = COLOR_W'(g); s.in_blue = COLOR_W'(b);
		return s;
	endfunction

	function automatic seg_t random_segment();
		seg_t s;
		int span;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		s = raw[$bits(seg_t)-1:0];
		case ($urandom_range(5))
			0: ;
			1: s.thickness = -COORD_W'($urandom_range(3000));
			default: begin
				span = 1 << $urandom_range(22, 2);
				s.start_x = COORD_W'(int'($urandom_range(2 * span)) - span);
				s.start_y = COORD_W'(int'($urandom_range(2 * span)) - span);
				s.end_x = s.start_x + COORD_W'(int'($urandom_range(2 * span)) - span);
				s.end_y = s.start_y + COORD_W'(int'($urandom_range(2 * span)) - span);
				s.thickness = COORD_W'($urandom_range(1 << $urandom_range(20, 1)));
			end
		endcase
		if ($urandom_range(1)) s.in_red = COLOR_W'(int'($urandom_range(5000)) - 400);
		if ($urandom_range(1)) s.in_green = COLOR_W'(int'($urandom_range(5000)) - 400);
		return s;
	endfunction

	task automatic test_directed();
		send_segment(mk(0, 0, 256, 0, 0, 0, 4096, -1));
		send_segment(mk(-8388608, 8388607, 8388607, -8388608, -8388608,
			-32768, 32767, 4097));
		send_segment(mk(0, 0, 256, 0, 512, 4096, 2048, 0));
		send_segment(mk(0, 0, 0, -256, 512, 100, 200, 300));
		send_segment(mk(100, 100, 100, 100, 256, 1, 2, 3));
		send_segment(mk(-8388608, -8388608, 8388607, 8388607, 8388607,
			32767, -32768, 4096));
		send_segment(mk(8388607, 0, -8388608, 1, 8388607, 5, 6, 7));
		send_segment(mk(8388000, 8388000, 8388100, 8388300, 30000, 9, 9, 9));
		send_segment(mk(0, 0, 3, 4, 1, 4095, 4097, 0));
		send_segment(mk(0, 0, -300, 700, 1000, 0, 0, 0));
		send_segment(mk(1, 1, 1, 2, 8388607, 0, 0, 0));
	endtask

	task automatic test_threshold();
		set_threshold(48'd25);
		send_segment(mk(0, 0, 3, 4, 256, 1, 1, 1));
		send_segment(mk(0, 0, 3, 5, 256, 1, 1, 1));
		send_segment(mk(0, 0, 3, 4, 0, 1, 1, 1));
		set_threshold({CFG_W{1'b1}});
		send_segment(mk(-8388608, -8388608, 8388607, 8388607, 256, 1, 1, 1));
		send_segment(mk(0, 0, 1000, 0, 256, 1, 1, 1));
	endtask

	task automatic test_random(int n, logic [CFG_W-1:0] thr, bit gaps);
		set_threshold(thr);
		gaps_on = gaps;
		repeat (n) send_segment(random_segment());
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_threshold();
		test_random(160, '0, 1'b1);
		test_random(140, 48'd1 << $urandom_range(40, 10), 1'b1);
		test_random(180, '0, 1'b0);
		drain();
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
